FILE: src/gcib_pkg.sv
`timescale 1ns / 1ps
// gcib_pkg: shared constants and the arctangent table for the bearing unit
// no dependencies; imported by gcib_sincos, gcib_atan2 and the top level

package gcib_pkg;

    // binary angles: a full turn is 2^32
    localparam logic [31:0] HALF_TURN    = 32'h8000_0000;
    localparam logic [32:0] QUARTER_TURN = 33'h0_4000_0000;

    // cordic gain compensation, q2.30
    localparam logic signed [32:0] CORDIC_GAIN = 33'sd652032874;

    // arctangent of 2^-i in binary-angle units
    function automatic logic [31:0] atan_bam(input int unsigned idx);
        logic [31:0] val;
        case (idx)
            0:       val = 32'd536870912;
            1:       val = 32'd316933406;
            2:       val = 32'd167458907;
            3:       val = 32'd85004756;
            4:       val = 32'd42667331;
            5:       val = 32'd21354465;
            6:       val = 32'd10679838;
            7:       val = 32'd5340245;
            8:       val = 32'd2670163;
            9:       val = 32'd1335087;
            10:      val = 32'd667544;
            11:      val = 32'd333772;
            12:      val = 32'd166886;
            13:      val = 32'd83443;
            14:      val = 32'd41722;
            15:      val = 32'd20861;
            16:      val = 32'd10430;
            17:      val = 32'd5215;
            18:      val = 32'd2608;
            19:      val = 32'd1304;
            20:      val = 32'd652;
            21:      val = 32'd326;
            22:      val = 32'd163;
            23:      val = 32'd81;
            24:      val = 32'd41;
            25:      val = 32'd20;
            26:      val = 32'd10;
            27:      val = 32'd5;
            28:      val = 32'd3;
            29:      val = 32'd1;
            30:      val = 32'd1;
            default: val = 32'd0;
        endcase
        return val;
    endfunction

endpackage

FILE: src/gcib_sincos.sv
`timescale 1ns / 1ps
// gcib_sincos: pipelined rotation cordic, binary angle in, q2.30 sine and cosine out
// depends on gcib_pkg

module gcib_sincos
    import gcib_pkg::*;
#(
    parameter int STAGES = 24
)
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                en,
    input  logic                in_valid,
    input  logic [31:0]         angle,
    output logic                out_valid,
    output logic signed [31:0]  sin_q30,
    output logic signed [31:0]  cos_q30
);

    logic signed [32:0] x_reg [0:STAGES];
    logic signed [32:0] y_reg [0:STAGES];
    logic signed [32:0] z_reg [0:STAGES];
    logic               neg_reg [0:STAGES];
    logic               v_reg [0:STAGES];
    logic signed [32:0] x_next [1:STAGES];
    logic signed [32:0] y_next [1:STAGES];
    logic signed [32:0] z_next [1:STAGES];
    logic signed [32:0] z_pre;
    logic signed [32:0] z_pre_next;
    logic               neg_pre_next;
    logic signed [31:0] sin_reg;
    logic signed [31:0] cos_reg;
    logic               vout_reg;

    // fold the angle into the right half plane
    always_comb
    begin
        z_pre        = {angle[31], angle};
        z_pre_next   = z_pre;
        neg_pre_next = 1'b0;
        if (z_pre > $signed(QUARTER_TURN))
        begin
            z_pre_next   = z_pre - $signed({1'b0, HALF_TURN});
            neg_pre_next = 1'b1;
        end
        else if (z_pre < -$signed(QUARTER_TURN))
        begin
            z_pre_next   = z_pre + $signed({1'b0, HALF_TURN});
            neg_pre_next = 1'b1;
        end
    end

    // one micro-rotation per stage
    always_comb
    begin
        for (int i = 0; i < STAGES; i++)
        begin
            if (z_reg[i] >= 0)
            begin
                x_next[i+1] = x_reg[i] - (y_reg[i] >>> i);
                y_next[i+1] = y_reg[i] + (x_reg[i] >>> i);
                z_next[i+1] = z_reg[i] - $signed({1'b0, atan_bam(i)});
            end
            else
            begin
                x_next[i+1] = x_reg[i] + (y_reg[i] >>> i);
                y_next[i+1] = y_reg[i] - (x_reg[i] >>> i);
                z_next[i+1] = z_reg[i] + $signed({1'b0, atan_bam(i)});
            end
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            x_reg[0]   <= CORDIC_GAIN;
            y_reg[0]   <= '0;
            z_reg[0]   <= z_pre_next;
            neg_reg[0] <= neg_pre_next;
            for (int i = 1; i <= STAGES; i++)
            begin
                x_reg[i]   <= x_next[i];
                y_reg[i]   <= y_next[i];
                z_reg[i]   <= z_next[i];
                neg_reg[i] <= neg_reg[i-1];
            end
            cos_reg <= neg_reg[STAGES] ? 32'(-x_reg[STAGES]) : 32'(x_reg[STAGES]);
            sin_reg <= neg_reg[STAGES] ? 32'(-y_reg[STAGES]) : 32'(y_reg[STAGES]);
        end
    end

    // valid bits
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i <= STAGES; i++)
            begin
                v_reg[i] <= 1'b0;
            end
            vout_reg <= 1'b0;
        end
        else if (en)
        begin
            v_reg[0] <= in_valid;
            for (int i = 1; i <= STAGES; i++)
            begin
                v_reg[i] <= v_reg[i-1];
            end
            vout_reg <= v_reg[STAGES];
        end
    end

    assign out_valid = vout_reg;
    assign sin_q30   = sin_reg;
    assign cos_q30   = cos_reg;

endmodule

FILE: src/gcib_atan2.sv
`timescale 1ns / 1ps
// gcib_atan2: pipelined vectoring cordic, returns atan2(y, x) as a binary angle
// depends on gcib_pkg; one tag bit rides along

module gcib_atan2
    import gcib_pkg::*;
#(
    parameter int STAGES = 24
)
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                en,
    input  logic                in_valid,
    input  logic signed [33:0]  y_in,
    input  logic signed [33:0]  x_in,
    input  logic                tag_in,
    output logic                out_valid,
    output logic [31:0]         angle,
    output logic                tag_out
);

    logic signed [35:0] x_reg [0:STAGES];
    logic signed [35:0] y_reg [0:STAGES];
    logic [31:0]        z_reg [0:STAGES];
    logic               tag_reg [0:STAGES];
    logic               v_reg [0:STAGES];
    logic signed [35:0] x_next [1:STAGES];
    logic signed [35:0] y_next [1:STAGES];
    logic [31:0]        z_next [1:STAGES];

    // one vectoring step per stage
    always_comb
    begin
        for (int i = 0; i < STAGES; i++)
        begin
            if (y_reg[i] > 0)
            begin
                x_next[i+1] = x_reg[i] + (y_reg[i] >>> i);
                y_next[i+1] = y_reg[i] - (x_reg[i] >>> i);
                z_next[i+1] = z_reg[i] + atan_bam(i);
            end
            else
            begin
                x_next[i+1] = x_reg[i] - (y_reg[i] >>> i);
                y_next[i+1] = y_reg[i] + (x_reg[i] >>> i);
                z_next[i+1] = z_reg[i] - atan_bam(i);
            end
        end
    end

    // payload registers, left half plane mirrored first
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            if (x_in < 0)
            begin
                x_reg[0] <= -36'(x_in);
                y_reg[0] <= -36'(y_in);
                z_reg[0] <= HALF_TURN;
            end
            else
            begin
                x_reg[0] <= 36'(x_in);
                y_reg[0] <= 36'(y_in);
                z_reg[0] <= '0;
            end
            tag_reg[0] <= tag_in;
            for (int i = 1; i <= STAGES; i++)
            begin
                x_reg[i]   <= x_next[i];
                y_reg[i]   <= y_next[i];
                z_reg[i]   <= z_next[i];
                tag_reg[i] <= tag_reg[i-1];
            end
        end
    end

    // valid bits
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i <= STAGES; i++)
            begin
                v_reg[i] <= 1'b0;
            end
        end
        else if (en)
        begin
            v_reg[0] <= in_valid;
            for (int i = 1; i <= STAGES; i++)
            begin
                v_reg[i] <= v_reg[i-1];
            end
        end
    end

    assign out_valid = v_reg[STAGES];
    assign angle     = z_reg[STAGES];
    assign tag_out   = tag_reg[STAGES];

endmodule

FILE: src/great_circle_initial_bearing_unit.sv
`timescale 1ns / 1ps
// great_circle_initial_bearing_unit: initial great-circle course between two positions
// depends on gcib_pkg, gcib_sincos and gcib_atan2
//
//  channel   signals                                  direction  meaning
//  pos       pos_valid, pos_stall, start/end lat/lon  in         one position pair per item
//  course    course_valid, course_stall, course_degrees out      one bearing per item
//
// one item per cycle while course_stall does not hold the pipeline; the delay is set by the two
// cordic pipelines (sine/cosine, then atan2) plus conversion and product stages.
// reset clears only the valid bits; payload registers are not reset.
// a stalled result freezes the whole pipeline, and pos_stall follows at once.

module great_circle_initial_bearing_unit
    import gcib_pkg::*;
#(
    parameter int CORDIC_STAGES       = 24,
    parameter int ANGLE_FRACTION_BITS = 22
)
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                pos_valid,
    output logic                pos_stall,
    input  logic signed [29:0]  start_latitude,
    input  logic signed [30:0]  start_longitude,
    input  logic signed [29:0]  end_latitude,
    input  logic signed [30:0]  end_longitude,
    output logic                course_valid,
    input  logic                course_stall,
    output logic [24:0]         course_degrees
);

    localparam int          DROP_BITS = 22 - ANGLE_FRACTION_BITS;
    localparam logic [30:0] KEEP_MASK = ~((31'd1 << DROP_BITS) - 31'd1);
    // 45 * 2^33 keeps the dividend positive without changing the quotient mod 2^32
    localparam logic [39:0] DIV_OFFSET = 40'd386547056640;
    localparam logic [39:0] HALF_STEP  = 40'd22;
    localparam logic [14:0] Q_PER_HI   = 15'd23301;
    localparam logic [4:0]  R_PER_HI   = 5'd31;
    localparam logic [26:0] RECIP_45   = 27'd95443718;
    localparam logic [24:0] FULL_Q16   = 25'd23592960;

    logic en;
    logic course_valid_reg;
    logic [24:0] course_reg;

    // global advance: move whenever the output register is free
    assign en        = !course_valid_reg || !course_stall;
    assign pos_stall = !en;

    // degrees to binary angle: floor((v*2^(32-f) + 180) / 360)
    logic signed [30:0] fld  [0:3];
    logic [39:0]        u_next [0:3];
    logic [39:0]        u_reg  [0:3];
    logic [25:0]        r_reg  [0:3];
    logic [31:0]        p1_reg [0:3];
    logic [31:0]        p1b_reg [0:3];
    logic [20:0]        qlo_reg [0:3];
    logic [31:0]        bam_reg [0:3];
    logic [34:0]        p1_full [0:3];
    logic [52:0]        p2_full [0:3];
    logic [25:0]        r_next [0:3];
    logic [37:0]        m_val  [0:3];
    logic [3:0]         cv_reg;

    assign fld[0] = {start_latitude[29], start_latitude};
    assign fld[1] = start_longitude;
    assign fld[2] = {end_latitude[29], end_latitude};
    assign fld[3] = end_longitude;

    // split the quotient by 45 over a high and a low 20-bit part
    always_comb
    begin
        for (int k = 0; k < 4; k++)
        begin
            m_val[k]   = {fld[k] & KEEP_MASK, 7'b0};
            u_next[k]  = {{2{m_val[k][37]}}, m_val[k]} + HALF_STEP + DIV_OFFSET;
            r_next[k]  = 26'(u_reg[k][39:20]) * 26'(R_PER_HI) + 26'(u_reg[k][19:0]);
            p1_full[k] = u_reg[k][39:20] * Q_PER_HI;
            p2_full[k] = r_reg[k] * RECIP_45;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int k = 0; k < 4; k++)
            begin
                u_reg[k]   <= u_next[k];
                r_reg[k]   <= r_next[k];
                p1_reg[k]  <= p1_full[k][31:0];
                qlo_reg[k] <= p2_full[k][52:32];
                p1b_reg[k] <= p1_reg[k];
                bam_reg[k] <= p1b_reg[k] + 32'(qlo_reg[k]);
            end
        end
    end

    // latitudes and longitude difference
    logic [31:0] lat1_reg;
    logic [31:0] lat2_reg;
    logic [31:0] dlon_reg;
    logic        dv_reg;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            lat1_reg <= bam_reg[0];
            lat2_reg <= bam_reg[2];
            dlon_reg <= bam_reg[3] - bam_reg[1];
        end
    end

    // sine and cosine of both latitudes and the longitude difference
    logic signed [31:0] s1, c1, s2, c2, sd, cd;
    logic sc_valid, sc_valid2, sc_valid3;

    gcib_sincos #(.STAGES(CORDIC_STAGES)) u_sc_lat1 (
        .clk(clk), .rst_n(rst_n), .en(en), .in_valid(dv_reg), .angle(lat1_reg),
        .out_valid(sc_valid), .sin_q30(s1), .cos_q30(c1)
    );

    gcib_sincos #(.STAGES(CORDIC_STAGES)) u_sc_lat2 (
        .clk(clk), .rst_n(rst_n), .en(en), .in_valid(dv_reg), .angle(lat2_reg),
        .out_valid(sc_valid2), .sin_q30(s2), .cos_q30(c2)
    );

    gcib_sincos #(.STAGES(CORDIC_STAGES)) u_sc_dlon (
        .clk(clk), .rst_n(rst_n), .en(en), .in_valid(dv_reg), .angle(dlon_reg),
        .out_valid(sc_valid3), .sin_q30(sd), .cos_q30(cd)
    );

    // products, q2.30 floored
    logic signed [63:0] prod_a1, prod_t1, prod_t2;
    logic signed [64:0] prod_t3;
    logic signed [32:0] a1_reg, a1b_reg, t1_reg, t1b_reg, t2_reg, t3_reg;
    logic signed [31:0] cd_reg;
    logic signed [33:0] a1c_reg, a2_reg;
    logic               zero_reg;
    logic [2:0]         pv_reg;

    assign prod_a1 = sd * c2;
    assign prod_t1 = c1 * s2;
    assign prod_t2 = s1 * c2;
    assign prod_t3 = t2_reg * cd_reg;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            a1_reg   <= prod_a1[62:30];
            t1_reg   <= prod_t1[62:30];
            t2_reg   <= prod_t2[62:30];
            cd_reg   <= cd;
            a1b_reg  <= a1_reg;
            t1b_reg  <= t1_reg;
            t3_reg   <= prod_t3[62:30];
            a1c_reg  <= 34'(a1b_reg);
            a2_reg   <= 34'(t1b_reg) - 34'(t3_reg);
            zero_reg <= (a1b_reg == '0) && (t1b_reg == t3_reg);
        end
    end

    // course angle
    logic [31:0] bearing_bam;
    logic        at_valid;
    logic        at_zero;

    gcib_atan2 #(.STAGES(CORDIC_STAGES)) u_atan2 (
        .clk(clk), .rst_n(rst_n), .en(en), .in_valid(pv_reg[2]),
        .y_in(a1c_reg), .x_in(a2_reg), .tag_in(zero_reg),
        .out_valid(at_valid), .angle(bearing_bam), .tag_out(at_zero)
    );

    // binary angle to degrees q9.16, rounded
    logic [40:0] deg_full;
    logic [24:0] deg_q16;

    assign deg_full = {9'b0, bearing_bam} * 41'd360 + 41'd32768;
    assign deg_q16  = deg_full[40:16];

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            if (at_zero || deg_q16 >= FULL_Q16)
            begin
                course_reg <= '0;
            end
            else
            begin
                course_reg <= deg_q16;
            end
        end
    end

    // valid bits
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cv_reg           <= '0;
            dv_reg           <= 1'b0;
            pv_reg           <= '0;
            course_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            cv_reg           <= {cv_reg[2:0], pos_valid};
            dv_reg           <= cv_reg[3];
            pv_reg           <= {pv_reg[1:0], sc_valid & sc_valid2 & sc_valid3};
            course_valid_reg <= at_valid;
        end
    end

    assign course_valid   = course_valid_reg;
    assign course_degrees = course_reg;

endmodule
